@@ rtl/sla_pkg.sv @@
package sla_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;

  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } sla_state_e;

endpackage

@@ rtl/serial_line_assembler_top.sv @@
// Channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------------
// in       | in_valid_i / in_stall_o    | rx_byte_i, frame_error_i, overrun_error_i
// out      | out_valid_o / out_stall_i  | line_byte_o, last_of_line_o, line_length_o,
//          |                            | overflow_o
//
// A dropped, ignored or appended byte is taken in ST_IDLE; the block stays ready for the next byte.
// A terminator on a non-empty line starts a readout of the line buffer, one byte at a time: each byte
// goes through address, registered RAM read and output register, and waits there during any output stall.
// An overflow result is loaded into the output register and then waits for the output handshake.
// Input is stalled for the whole readout. Reset empties the line; the buffer is not cleared.
module serial_line_assembler_top
  import sla_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              frame_error_i,
  input  logic              overrun_error_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] line_byte_o,
  output logic              last_of_line_o,
  output logic [LEN_W-1:0]  line_length_o,
  output logic              overflow_o
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned CW = $clog2(LINE_DEPTH + 1);

  sla_state_e        state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;

  logic              in_xfer, out_xfer, good, full, is_term, is_nul;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;

  assign in_xfer  = in_valid_i && (state_q == ST_IDLE);
  assign out_xfer = (state_q == ST_SEND) && !out_stall_i;
  assign good     = in_xfer && !frame_error_i && !overrun_error_i;
  assign full     = (fill_q == CW'(LINE_DEPTH));
  assign is_term  = (rx_byte_i == CHAR_LF) || (rx_byte_i == CHAR_CR);
  assign is_nul   = (rx_byte_i == CHAR_NUL);
  assign ram_we   = good && !full && !is_nul && !is_term;

  sla_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(rx_byte_i),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (good && full) begin
          state_d = ST_SEND;
        end else if (good && is_term && (fill_q != '0)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_SEND;
      ST_SEND: begin
        if (out_xfer) begin
          state_d = last_q ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_d   = fill_q;
    rd_idx_d = rd_idx_q;
    byte_d   = byte_q;
    last_d   = last_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (good && full) begin
          // drop the line, report overflow
          fill_d = '0;
          byte_d = '0;
          last_d = 1'b1;
          len_d  = '0;
          ovf_d  = 1'b1;
        end else if (ram_we) begin
          fill_d = fill_q + CW'(1);
        end else if (good && is_term && (fill_q != '0)) begin
          len_d    = LEN_W'(fill_q);
          rd_idx_d = '0;
          ovf_d    = 1'b0;
          fill_d   = '0;
        end
      end
      ST_LOAD: begin
        byte_d = ram_rdata;
        last_d = (LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q;
      end
      ST_SEND: begin
        if (out_xfer && !last_q) begin
          rd_idx_d = rd_idx_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
    len_q    <= len_d;
    ovf_q    <= ovf_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = (state_q == ST_SEND);
  assign line_byte_o    = byte_q;
  assign last_of_line_o = last_q;
  assign line_length_o  = len_q;
  assign overflow_o     = ovf_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(LINE_DEPTH))
    else $error("line fill count beyond buffer depth");

  a_ovf_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> last_of_line_o && (line_byte_o == '0) &&
                                  (line_length_o == '0))
    else $error("overflow result carries line data");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_o |-> (line_length_o != '0) &&
                                   (line_length_o < LEN_W'(LINE_DEPTH)))
    else $error("line run with bad length");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_of_line_o |=> !in_stall_o && (fill_q == '0))
    else $error("input not released after final transfer of a run");

endmodule

@@ rtl/sla_ram.sv @@
module sla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
